// File: design/sha1_pkg.sv
package sha1_pkg;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned NUM_WORDS  = 5;
    localparam int unsigned RING_DEPTH = 16;

    localparam logic [6:0] ROUND_LAST    = 7'(NUM_ROUNDS - 1);
    localparam logic [6:0] PHASE1_START  = 7'd20;
    localparam logic [6:0] PHASE2_START  = 7'd40;
    localparam logic [6:0] PHASE3_START  = 7'd60;
    localparam logic [2:0] WORD_IDX_LAST = 3'(NUM_WORDS - 1);
    localparam logic [5:0] FILL_LAST     = 6'd63;
    localparam logic [5:0] LEN_START     = 6'd56;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      push;
        byte_sel_t byte_sel;
        logic      count_bits;
        logic      load_vars;
        logic      do_round;
        logic [6:0] round_cnt;
        logic      add_chain;
        logic      reinit;
        logic [2:0] word_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
    } dp_status_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

endpackage

// File: design/sha1_dpath.sv
module sha1_dpath
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  in_byte,
    output dp_status_t  status,
    output logic [31:0] digest_word
);

    logic [31:0] chain_reg [NUM_WORDS];
    logic [31:0] var_reg   [NUM_WORDS];
    logic [31:0] w_reg     [RING_DEPTH];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;

    logic [7:0]  push_byte;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [31:0] w_new;
    logic [5:0]  len_base;

    assign len_base = {~fill_reg[2:0], 3'b000};

    always_comb
    begin
        case (cmd.byte_sel)
            SEL_DATA: push_byte = in_byte;
            SEL_MARK: push_byte = PAD_MARK;
            SEL_LEN:  push_byte = bits_reg[len_base +: 8];
            default:  push_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        if (cmd.round_cnt < PHASE1_START)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (~var_reg[1] & var_reg[3]);
            k_val = K0;
        end
        else if (cmd.round_cnt < PHASE2_START)
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K1;
        end
        else if (cmd.round_cnt < PHASE3_START)
        begin
            f_val = (var_reg[1] & var_reg[2]) | (var_reg[1] & var_reg[3])
                  | (var_reg[2] & var_reg[3]);
            k_val = K2;
        end
        else
        begin
            f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
            k_val = K3;
        end
    end

    // Slot 0 always holds the schedule word of the current round.
    assign t_val = rotl(var_reg[0], 5) + f_val + var_reg[4] + k_val + w_reg[0];
    assign w_new = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
            fill_reg     <= '0;
            bits_reg     <= '0;
        end
        else if (cmd.reinit)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
            fill_reg     <= '0;
            bits_reg     <= '0;
        end
        else
        begin
            if (cmd.add_chain)
            begin
                for (int i = 0; i < NUM_WORDS; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
            if (cmd.push)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (cmd.count_bits)
            begin
                bits_reg <= bits_reg + 64'd8;
            end
        end
    end

    // The block buffer shifts in bytes from the bottom so that a full block
    // sits in big-endian word order, oldest word in slot 0.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            for (int i = 0; i < RING_DEPTH - 1; i++)
            begin
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            end
            w_reg[RING_DEPTH - 1] <= {w_reg[RING_DEPTH - 1][23:0], push_byte};
        end
        else if (cmd.do_round)
        begin
            for (int i = 0; i < RING_DEPTH - 1; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[RING_DEPTH - 1] <= w_new;
        end

        if (cmd.load_vars)
        begin
            for (int i = 0; i < NUM_WORDS; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.do_round)
        begin
            var_reg[0] <= t_val;
            var_reg[1] <= var_reg[0];
            var_reg[2] <= rotl(var_reg[1], 30);
            var_reg[3] <= var_reg[2];
            var_reg[4] <= var_reg[3];
        end
    end

    always_comb
    begin
        case (cmd.word_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    assign status.fill = fill_reg;

endmodule

// File: design/sha1_ctrl.sv
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_has_byte,
    input  logic       in_last,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_index,
    output logic       out_last,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [6:0] rnd_cnt_reg, rnd_cnt_next;
    logic [2:0] idx_reg, idx_next;
    logic       pad_pend_reg, pad_pend_next;
    logic       pad_first_reg, pad_first_next;
    logic       final_blk_reg, final_blk_next;

    logic in_acc;
    logic out_acc;
    logic blk_full;

    assign in_acc   = (state_reg == S_IDLE) && in_valid;
    assign out_acc  = (state_reg == S_OUT) && out_ready;
    assign blk_full = (status.fill == FILL_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rnd_cnt_reg   <= '0;
            idx_reg       <= '0;
            pad_pend_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            final_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rnd_cnt_reg   <= rnd_cnt_next;
            idx_reg       <= idx_next;
            pad_pend_reg  <= pad_pend_next;
            pad_first_reg <= pad_first_next;
            final_blk_reg <= final_blk_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        rnd_cnt_next   = rnd_cnt_reg;
        idx_next       = idx_reg;
        pad_pend_next  = pad_pend_reg;
        pad_first_next = pad_first_reg;
        final_blk_next = final_blk_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_has_byte && blk_full)
                    begin
                        state_next     = S_ROUND;
                        rnd_cnt_next   = '0;
                        pad_pend_next  = in_last;
                        pad_first_next = in_last;
                    end
                    else if (in_last)
                    begin
                        state_next     = S_PAD;
                        pad_pend_next  = 1'b1;
                        pad_first_next = 1'b1;
                    end
                end
            end
            S_PAD:
            begin
                pad_first_next = 1'b0;
                if (pad_first_reg)
                begin
                    // The length fits behind the mark only below byte 56.
                    final_blk_next = (status.fill < LEN_START);
                end
                if (blk_full)
                begin
                    state_next   = S_ROUND;
                    rnd_cnt_next = '0;
                end
            end
            S_ROUND:
            begin
                rnd_cnt_next = rnd_cnt_reg + 7'd1;
                if (rnd_cnt_reg == ROUND_LAST)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (final_blk_reg)
                begin
                    state_next = S_OUT;
                    idx_next   = '0;
                end
                else if (pad_pend_reg)
                begin
                    state_next = S_PAD;
                    if (!pad_first_reg)
                    begin
                        final_blk_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == WORD_IDX_LAST)
                    begin
                        state_next     = S_IDLE;
                        idx_next       = '0;
                        pad_pend_next  = 1'b0;
                        pad_first_next = 1'b0;
                        final_blk_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.byte_sel   = SEL_ZERO;
        cmd.round_cnt  = rnd_cnt_reg;
        cmd.word_sel   = idx_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_acc && in_has_byte)
                begin
                    cmd.push       = 1'b1;
                    cmd.byte_sel   = SEL_DATA;
                    cmd.count_bits = 1'b1;
                    cmd.load_vars  = blk_full;
                end
            end
            S_PAD:
            begin
                cmd.push      = 1'b1;
                cmd.load_vars = blk_full;
                if (pad_first_reg)
                begin
                    cmd.byte_sel = SEL_MARK;
                end
                else if (final_blk_reg && (status.fill >= LEN_START))
                begin
                    cmd.byte_sel = SEL_LEN;
                end
                else
                begin
                    cmd.byte_sel = SEL_ZERO;
                end
            end
            S_ROUND:
            begin
                cmd.do_round = 1'b1;
            end
            S_ADD:
            begin
                cmd.add_chain = 1'b1;
            end
            S_OUT:
            begin
                out_valid  = 1'b1;
                cmd.reinit = out_acc && (idx_reg == WORD_IDX_LAST);
            end
            default:
            begin
                cmd.byte_sel = SEL_ZERO;
            end
        endcase
    end

    assign out_index = idx_reg;
    assign out_last  = (idx_reg == WORD_IDX_LAST);

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (rnd_cnt_reg <= ROUND_LAST))
        else $error("round counter ran past the last round");

    a_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && cmd.do_round))
        else $error("byte push collided with a compression round");

    a_final_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && final_blk_reg) |=> (state_reg == S_OUT && idx_reg == 3'd0))
        else $error("final block did not lead to digest output");

    a_len_final: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push && cmd.byte_sel == SEL_LEN) |-> (status.fill >= LEN_START))
        else $error("length byte placed outside the tail of the block");

endmodule

// File: design/sha1_hash_engine_core.sv
// SHA-1 hashing engine.
// Input stream: one word per message byte. s_axis_tdata carries the byte,
// s_axis_tuser says whether the byte is present, and s_axis_tlast closes the
// message. A word with tuser low and tlast high closes the message as it
// stands, which gives the empty-message digest when nothing was sent.
// Output stream: five digest words h0..h4 per message; m_axis_tuser gives
// the word position and m_axis_tlast marks h4.
// Flow: a byte is taken while the engine is idle. Each 64th byte, and each block
// built during padding, starts the compression, which runs its rounds on one
// shared round unit and then folds the result into the chaining words; input
// is held off meanwhile. Closing a message pads one byte per cycle, pausing
// for the compression after a full block, up to 72 bytes with two compressions.
// The engine works on one word at a time: while the digest waits on a low
// m_axis_tready no new input is taken. After the fifth digest word the
// engine reloads the initial hash values and is ready for the next message.
// Reset puts the engine idle with the initial hash values and zero length.
module sha1_hash_engine_core
    import sha1_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;

    sha1_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_has_byte (s_axis_tuser),
        .in_last     (s_axis_tlast),
        .in_ready    (s_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_index   (m_axis_tuser),
        .out_last    (m_axis_tlast),
        .status      (status),
        .cmd         (cmd)
    );

    sha1_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_byte     (s_axis_tdata),
        .status      (status),
        .digest_word (m_axis_tdata)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned ITEMS_WANTED = 480;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned TAIL_CYCLES  = 400;

    localparam logic [31:0] SHA1_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       last;
    } msg_word_t;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;   // [0] has_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] digest_word
    logic [2:0]  m_axis_tuser;          // [2:0] word_index
    logic        m_axis_tlast;

    msg_word_t    words_pending [$];
    digest_word_t digests_due [$];

    // Running hash state of the predictor.
    logic [31:0] hash_h [5];
    logic [7:0]  blk [64];
    int unsigned fill_cnt;
    logic [63:0] msg_bits;

    int unsigned n_items;
    int unsigned words_sent;
    int unsigned digests_seen;
    int unsigned words_checked;
    int unsigned errors;
    int unsigned quiet;

    // Idle percentages per phase: none, sender, receiver, both.
    int unsigned send_idle [4] = '{0, 50, 0, 29};
    int unsigned recv_idle [4] = '{0, 0, 50, 29};

    sha1_hash_engine_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 5; i++)
            hash_h[i] = SHA1_INIT[i];
        fill_cnt = 0;
        msg_bits = '0;
    endfunction

    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i >= 16)
            begin
                x = w[(i - 3) & 15] ^ w[(i - 8) & 15] ^ w[(i - 14) & 15] ^ w[i & 15];
                w[i & 15] = rol(x, 1);
            end
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5A827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ED9EBA1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8F1BBCDC;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i & 15];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    // Takes one accepted input word; on a closing word, pads the message and
    // queues the five digest words.
    function automatic void sha1_absorb(input msg_word_t wd);
        int unsigned  pos;
        digest_word_t r;
        if (wd.has)
        begin
            blk[fill_cnt] = wd.data;
            fill_cnt++;
            msg_bits += 64'd8;
            if (fill_cnt == 64)
            begin
                sha1_compress();
                fill_cnt = 0;
            end
        end
        if (!wd.last)
            return;
        pos = fill_cnt;
        blk[pos] = 8'h80;
        pos++;
        // No room left for the length field, so an extra block is needed.
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            sha1_compress();
            pos = 0;
        end
        while (pos < 56)
        begin
            blk[pos] = 8'h00;
            pos++;
        end
        for (int i = 0; i < 8; i++)
            blk[56 + i] = msg_bits[8 * (7 - i) +: 8];
        sha1_compress();
        for (int i = 0; i < 5; i++)
        begin
            r.value = hash_h[i];
            r.index = 3'(i);
            r.last  = (i == 4);
            digests_due.insert(digests_due.size(), r);
        end
        hash_restart();
    endfunction

    function automatic void queue_word(input logic [7:0] data, input logic has,
                                       input logic last);
        msg_word_t wd;
        wd.data = data;
        wd.has  = has;
        wd.last = last;
        words_pending.insert(words_pending.size(), wd);
    endfunction

    function automatic int unsigned phase_now();
        int unsigned p;
        p = (n_items == 0) ? 0 : (words_sent * 4) / n_items;
        return (p > 3) ? 3 : p;
    endfunction

    // Input driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tuser  <= 1'b0;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                msg_word_t wd;
                wd.data = s_axis_tdata;
                wd.has  = s_axis_tuser;
                wd.last = s_axis_tlast;
                sha1_absorb(wd);
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (words_pending.size() != 0 &&
                    $urandom_range(99) >= send_idle[phase_now()])
                begin
                    msg_word_t nx;
                    nx = words_pending.pop_front();
                    s_axis_tdata  <= nx.data;
                    s_axis_tuser  <= nx.has;
                    s_axis_tlast  <= nx.last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle[phase_now()]);
    end

    // Digest monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (digests_due.size() == 0)
            begin
                $error("unexpected digest word %h, index %0d", m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                digest_word_t ex;
                ex = digests_due.pop_front();
                words_checked++;
                if (ex.last)
                    digests_seen++;
                if (m_axis_tdata !== ex.value)
                begin
                    $error("digest_word: expected %h, got %h", ex.value, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== ex.index)
                begin
                    $error("word_index: expected %0d, got %0d", ex.index, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== ex.last)
                begin
                    $error("last_word: expected %0d, got %0d", ex.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
                $display("tb: done, errors");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        int unsigned sel;
        int unsigned len;
        logic        tail_has;
        words_sent    = 0;
        digests_seen  = 0;
        words_checked = 0;
        errors        = 0;
        quiet         = 0;
        hash_restart();
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;

        // Directed: an idle word, empty messages, short messages, byte extremes,
        // and a close without a byte carrying junk data.
        queue_word(8'hA5, 1'b0, 1'b0);
        queue_word(8'h00, 1'b0, 1'b1);
        queue_word(8'hFF, 1'b0, 1'b1);
        queue_word(8'h61, 1'b1, 1'b0);
        queue_word(8'h62, 1'b1, 1'b0);
        queue_word(8'h63, 1'b1, 1'b1);
        queue_word(8'hFF, 1'b1, 1'b1);
        queue_word(8'h00, 1'b1, 1'b1);
        queue_word(8'h3C, 1'b1, 1'b0);
        queue_word(8'h5A, 1'b0, 1'b0);
        queue_word(8'hC3, 1'b1, 1'b0);
        queue_word(8'h5A, 1'b0, 1'b1);
        queue_word(8'h80, 1'b1, 1'b0);
        queue_word(8'h01, 1'b1, 1'b1);

        // Random messages; lengths favor short ones but regularly hit the
        // padding boundaries around one and two full blocks.
        while (words_pending.size() < ITEMS_WANTED)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
                len = $urandom_range(8);
            else if (sel < 80)
                len = $urandom_range(70, 9);
            else
            begin
                case ($urandom_range(9))
                    0: len = 55;
                    1: len = 56;
                    2: len = 57;
                    3: len = 63;
                    4: len = 64;
                    5: len = 65;
                    6: len = 119;
                    7: len = 120;
                    8: len = 127;
                    default: len = 128;
                endcase
            end
            tail_has = (len != 0) && $urandom_range(1);
            for (int j = 0; j < len; j++)
            begin
                if ($urandom_range(24) == 0)
                    queue_word(8'($urandom), 1'b0, 1'b0);
                queue_word(8'($urandom), 1'b1, tail_has && (j == len - 1));
            end
            if (!tail_has)
                queue_word(8'($urandom), 1'b0, 1'b1);
        end
        // Two stray idle words at the very end.
        queue_word(8'($urandom), 1'b0, 1'b0);
        queue_word(8'($urandom), 1'b0, 1'b0);
        n_items = words_pending.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (words_pending.size() != 0 || s_axis_tvalid || digests_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (digests_due.size() != 0)
        begin
            $error("%0d digest words never arrived", digests_due.size());
            errors++;
        end
        $display("Sent %0d input words under four idle/stall mixes; checked %0d digest words",
                 words_sent, words_checked);
        $display("covering %0d messages, empty and block-boundary lengths among them.",
                 digests_seen);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
